// ===== rtl/core/osp_pkg.sv =====
// Shared types and constants for the odd-only prime sieve unit.
package osp_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SREAD,
    ST_SCHK,
    ST_MARK,
    ST_SCAN,
    ST_DONE
  } osp_state_t;

  // Smallest prime, and first odd candidate (map entry 0)
  localparam int FIRST_PRIME = 2;
  localparam int FIRST_ODD   = 3;

endpackage

// ===== rtl/core/osp_map_ram.sv =====
// One-bit composite map memory: one write port, one read port, registered read data.
module osp_map_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/osp_ctrl.sv =====
// Sieve sequencer: clears, marks and scans the composite map for one limit word.
module osp_ctrl #(
  parameter int LIMIT_BITS = 16,
  parameter int MAP_DEPTH  = 32768,
  parameter int MAP_AW     = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LIMIT_BITS-1:0] in_limit,
  output logic                  map_we,
  output logic [MAP_AW-1:0]     map_waddr,
  output logic                  map_wdata,
  output logic [MAP_AW-1:0]     map_raddr,
  input  logic                  map_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [LIMIT_BITS-1:0] res_count,
  output logic [LIMIT_BITS-1:0] res_last
);
  import osp_pkg::*;

  localparam int CNT_W = MAP_AW + 1;
  localparam int PSQ_W = LIMIT_BITS + 2;
  localparam int CMP_W = (PSQ_W > CNT_W) ? PSQ_W : CNT_W;
  localparam int VAL_W = MAP_AW + 2;

  osp_state_t            state_r, state_nxt;
  logic [LIMIT_BITS-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0]      odd_cnt_r, odd_cnt_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [PSQ_W-1:0]      p_r, p_nxt;
  logic [PSQ_W-1:0]      psq_r, psq_nxt;
  logic [PSQ_W-1:0]      j_r, j_nxt;
  logic                  scan_vld_r, scan_vld_nxt;
  logic [MAP_AW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [LIMIT_BITS-1:0] count_r, count_nxt;
  logic [LIMIT_BITS-1:0] last_r, last_nxt;

  logic                  idx_live;
  logic                  sieve_go;
  logic                  j_live;
  logic [LIMIT_BITS-1:0] half_limit;
  logic [CMP_W-1:0]      half_ext;
  logic [VAL_W-1:0]      scan_val;

  // Candidate index still inside the map span of this run
  assign idx_live = CMP_W'(idx_r) < CMP_W'(odd_cnt_r);
  // Next prime candidate p still has p*p <= limit-1
  assign sieve_go = idx_live && (CMP_W'(psq_r) < CMP_W'(limit_r));
  // Mark pointer still inside the span
  assign j_live   = CMP_W'(j_r) < CMP_W'(odd_cnt_r);

  // Odd candidates below the incoming limit, before clamping to the map
  assign half_limit = (in_limit - LIMIT_BITS'(FIRST_PRIME)) >> 1;
  assign half_ext   = CMP_W'(half_limit);

  // Odd value for a scanned entry: 3 + 2*idx
  assign scan_val = VAL_W'({scan_idx_r, 1'b1}) + VAL_W'(FIRST_PRIME);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (!idx_live) begin
          state_nxt = ST_SREAD;
        end
      end
      ST_SREAD: begin
        state_nxt = sieve_go ? ST_SCHK : ST_SCAN;
      end
      ST_SCHK: begin
        state_nxt = map_rdata ? ST_SREAD : ST_MARK;
      end
      ST_MARK: begin
        if (!j_live) begin
          state_nxt = ST_SREAD;
        end
      end
      ST_SCAN: begin
        if (!idx_live && !scan_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory port control
  always_comb begin
    limit_nxt    = limit_r;
    odd_cnt_nxt  = odd_cnt_r;
    idx_nxt      = idx_r;
    p_nxt        = p_r;
    psq_nxt      = psq_r;
    j_nxt        = j_r;
    scan_vld_nxt = 1'b0;
    scan_idx_nxt = scan_idx_r;
    count_nxt    = count_r;
    last_nxt     = last_r;
    map_we       = 1'b0;
    map_waddr    = idx_r[MAP_AW-1:0];
    map_wdata    = 1'b0;
    map_raddr    = idx_r[MAP_AW-1:0];
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          limit_nxt = in_limit;
          idx_nxt   = '0;
          p_nxt     = PSQ_W'(FIRST_ODD);
          psq_nxt   = PSQ_W'(FIRST_ODD * FIRST_ODD);
          if (in_limit > LIMIT_BITS'(FIRST_PRIME)) begin
            count_nxt = LIMIT_BITS'(1);
            last_nxt  = LIMIT_BITS'(FIRST_PRIME);
          end else begin
            count_nxt = '0;
            last_nxt  = '0;
          end
          // Span of odd entries used by this run
          if (in_limit <= LIMIT_BITS'(FIRST_ODD)) begin
            odd_cnt_nxt = '0;
          end else if (half_ext > CMP_W'(MAP_DEPTH)) begin
            odd_cnt_nxt = CNT_W'(MAP_DEPTH);
          end else begin
            odd_cnt_nxt = CNT_W'(half_ext);
          end
        end
      end
      ST_CLEAR: begin
        if (idx_live) begin
          map_we    = 1'b1;
          map_wdata = 1'b0;
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          idx_nxt = '0;
        end
      end
      ST_SREAD: begin
        if (!sieve_go) begin
          idx_nxt = '0;
        end
      end
      ST_SCHK: begin
        if (!map_rdata) begin
          // first multiple is p*p, at index (p*p-3)/2
          j_nxt = (psq_r - PSQ_W'(FIRST_ODD)) >> 1;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          p_nxt   = p_r + PSQ_W'(2);
          psq_nxt = psq_r + (p_r << 2) + PSQ_W'(4);
        end
      end
      ST_MARK: begin
        map_waddr = j_r[MAP_AW-1:0];
        if (j_live) begin
          map_we    = 1'b1;
          map_wdata = 1'b1;
          j_nxt     = j_r + p_r;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          p_nxt   = p_r + PSQ_W'(2);
          psq_nxt = psq_r + (p_r << 2) + PSQ_W'(4);
        end
      end
      ST_SCAN: begin
        // read one entry per cycle, tally the entry read last cycle
        scan_vld_nxt = idx_live;
        scan_idx_nxt = idx_r[MAP_AW-1:0];
        if (idx_live) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (scan_vld_r && !map_rdata) begin
          count_nxt = count_r + LIMIT_BITS'(1);
          last_nxt  = LIMIT_BITS'(scan_val);
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= scan_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    limit_r    <= limit_nxt;
    odd_cnt_r  <= odd_cnt_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    psq_r      <= psq_nxt;
    j_r        <= j_nxt;
    scan_idx_r <= scan_idx_nxt;
    count_r    <= count_nxt;
    last_r     <= last_nxt;
  end

  assign res_count = count_r;
  assign res_last  = last_r;

endmodule

// ===== rtl/core/odd_only_prime_sieve_unit.sv =====
// Per accepted word: clear N = min((limit-2)/2, MAP_DEPTH) odd entries, then for each
//   candidate p with p*p < limit read its entry and, if p is prime, mark its odd multiples
//   from p*p, then scan the N entries. Clear and scan take one entry per cycle, and marks
//   are written one per cycle.
// Throughput: one word in flight; the next is taken in the cycle after the result moves
//   to the output register. Reset (rst_n, sync, active low) idles the sequencer and clears out_valid.
module odd_only_prime_sieve_unit #(
  parameter int LIMIT_BITS = 16,
  parameter int MAP_DEPTH  = 32768
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LIMIT_BITS-1:0] in_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LIMIT_BITS-1:0] out_prime_count,
  output logic [LIMIT_BITS-1:0] out_last_prime
);
  import osp_pkg::*;

  localparam int MAP_AW = $clog2(MAP_DEPTH);

  logic                  map_we;
  logic [MAP_AW-1:0]     map_waddr;
  logic                  map_wdata;
  logic [MAP_AW-1:0]     map_raddr;
  logic                  map_rdata;
  logic                  res_valid;
  logic                  res_ready;
  logic [LIMIT_BITS-1:0] res_count;
  logic [LIMIT_BITS-1:0] res_last;

  logic                  out_valid_r, out_valid_nxt;
  logic [LIMIT_BITS-1:0] out_count_r, out_count_nxt;
  logic [LIMIT_BITS-1:0] out_last_r, out_last_nxt;

  osp_ctrl #(
    .LIMIT_BITS (LIMIT_BITS),
    .MAP_DEPTH  (MAP_DEPTH),
    .MAP_AW     (MAP_AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_limit  (in_limit),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_count (res_count),
    .res_last  (res_last)
  );

  osp_map_ram #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAP_AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Output register: takes a result when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = res_count;
      out_last_nxt  = res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_count = out_count_r;
  assign out_last_prime  = out_last_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the odd-only prime sieve unit: directed limits, then random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import osp_pkg::*;

  localparam int LIMIT_BITS     = 16;
  localparam int MAP_DEPTH      = 32768;
  localparam int RANDOM_WORDS   = 95;
  localparam int LARGE_FLOOR    = 2048;
  localparam int WATCHDOG_LIMIT = 600000;
  localparam int TAIL_CYCLES    = 200;

  typedef logic [LIMIT_BITS-1:0] word_t;

  // Expected result for one limit
  typedef struct {
    word_t limit;
    word_t prime_count;
    word_t last_prime;
  } sieve_result_t;

  // Directed row: result typed in only where it is plain to see
  typedef struct {
    word_t limit;
    bit    typed;
    word_t prime_count;
    word_t last_prime;
  } limit_row_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  word_t in_limit;
  logic  out_valid;
  logic  out_ready;
  word_t out_prime_count;
  word_t out_last_prime;

  sieve_result_t results_due[$];
  bit            odd_composite[MAP_DEPTH];
  int unsigned   next_gap = 0;
  int unsigned   words_sent = 0;
  int unsigned   large_words = 0;
  int unsigned   largest_limit = 0;
  int unsigned   results_checked = 0;
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;

  limit_row_t directed_rows[] = '{
    '{16'd0,     1'b1, 16'd0,    16'd0},
    '{16'd1,     1'b1, 16'd0,    16'd0},
    '{16'd2,     1'b1, 16'd0,    16'd0},
    '{16'd3,     1'b1, 16'd1,    16'd2},
    '{16'd4,     1'b1, 16'd2,    16'd3},
    '{16'd5,     1'b0, 16'd0,    16'd0},
    '{16'd9,     1'b0, 16'd0,    16'd0},
    '{16'd10,    1'b0, 16'd0,    16'd0},
    '{16'd11,    1'b0, 16'd0,    16'd0},
    '{16'd25,    1'b0, 16'd0,    16'd0},
    '{16'd26,    1'b0, 16'd0,    16'd0},
    '{16'd27,    1'b0, 16'd0,    16'd0},
    '{16'd49,    1'b0, 16'd0,    16'd0},
    '{16'd50,    1'b0, 16'd0,    16'd0},
    '{16'd121,   1'b0, 16'd0,    16'd0},
    '{16'd122,   1'b0, 16'd0,    16'd0},
    '{16'd169,   1'b0, 16'd0,    16'd0},
    '{16'd256,   1'b0, 16'd0,    16'd0},
    '{16'd1000,  1'b1, 16'd168,  16'd997},
    '{16'd1024,  1'b0, 16'd0,    16'd0},
    '{16'd4095,  1'b0, 16'd0,    16'd0},
    '{16'd32768, 1'b0, 16'd0,    16'd0},
    '{16'd65535, 1'b1, 16'd6542, 16'd65521}
  };

  odd_only_prime_sieve_unit #(
    .LIMIT_BITS(LIMIT_BITS),
    .MAP_DEPTH (MAP_DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_limit       (in_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_count(out_prime_count),
    .out_last_prime (out_last_prime)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Odd-only sieve: entry k stands for 3+2k; count 2 plus every unmarked entry
  function automatic sieve_result_t count_primes_below(input word_t limit);
    sieve_result_t res;
    int unsigned   lim;
    int unsigned   odd_n;
    int unsigned   root;
    int unsigned   n_sieve;
    int unsigned   p;
    int unsigned   total;
    int unsigned   largest;
    lim     = 32'(limit);
    total   = 0;
    largest = 0;
    foreach (odd_composite[k]) odd_composite[k] = 1'b0;
    if (lim > 2) begin
      total   = 1;
      largest = FIRST_PRIME;
    end
    if (lim > 3) begin
      odd_n = (lim - 2) / 2;
      if (odd_n > MAP_DEPTH) odd_n = MAP_DEPTH;
      root = 0;
      while ((root + 1) * (root + 1) <= lim - 1) root++;
      n_sieve = (root < 3) ? 0 : ((root - 3) / 2 + 1);
      if (n_sieve > odd_n) n_sieve = odd_n;
      // mark odd multiples from p*p upward
      for (int unsigned i = 0; i < n_sieve; i++) begin
        if (!odd_composite[i]) begin
          p = FIRST_ODD + 2 * i;
          for (int unsigned j = (p * p - FIRST_ODD) / 2; j < odd_n; j += p)
            odd_composite[j] = 1'b1;
        end
      end
      // scan for survivors
      for (int unsigned i = 0; i < odd_n; i++) begin
        if (!odd_composite[i]) begin
          total++;
          largest = FIRST_ODD + 2 * i;
        end
      end
    end
    res.limit       = limit;
    res.prime_count = total[LIMIT_BITS-1:0];
    res.last_prime  = largest[LIMIT_BITS-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Present one limit word and hold it until taken
  task automatic offer_limit(input word_t limit, input sieve_result_t due,
                             input bit drop_after);
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_limit <= limit;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(due);
    words_sent++;
    if (limit >= LARGE_FLOOR) large_words++;
    if (32'(limit) > largest_limit) largest_limit = 32'(limit);
    next_gap = pick_gap();
    if (drop_after || next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Result side: bursts of ready, short stalls, a few long ones
  initial begin
    int unsigned run;
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 4);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    sieve_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: count %0d last %0d",
                   out_prime_count, out_last_prime);
      end else begin
        due = results_due.pop_front();
        results_checked++;
        if (out_prime_count !== due.prime_count || out_last_prime !== due.last_prime) begin
          mismatches++;
          if (mismatches <= 10)
            $display("limit %0d: expected count %0d last %0d, got count %0d last %0d",
                     due.limit, due.prime_count, due.last_prime,
                     out_prime_count, out_last_prime);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sieve_result_t due;
    word_t         limit;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_limit = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small-limit corners, squares of odd primes, extremes
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        due.limit       = directed_rows[i].limit;
        due.prime_count = directed_rows[i].prime_count;
        due.last_prime  = directed_rows[i].last_prime;
      end else begin
        due = count_primes_below(directed_rows[i].limit);
      end
      offer_limit(directed_rows[i].limit, due, i == directed_rows.size() - 1);
    end
    wait_results_drained();

    // Random: mostly small limits, a few large ones to keep the run short
    for (int idx = 0; idx < RANDOM_WORDS; idx++) begin
      if (idx % 25 == 12)
        limit = word_t'($urandom_range(LARGE_FLOOR, 65535));
      else if ($urandom_range(0, 9) == 0)
        limit = word_t'($urandom_range(0, 8));
      else
        limit = word_t'($urandom_range(0, 1023));
      due = count_primes_below(limit);
      offer_limit(limit, due, idx == RANDOM_WORDS / 2 - 1 || idx == RANDOM_WORDS - 1);
      // hold off mid-run until the unit has delivered everything
      if (idx == RANDOM_WORDS / 2 - 1) wait_results_drained();
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d limits (%0d of them %0d or more, largest %0d), checked %0d results",
             words_sent, large_words, LARGE_FLOOR, largest_limit, results_checked);
    $display("Mismatches: %0d, results still outstanding: %0d",
             mismatches, results_due.size());
    if (mismatches == 0 && results_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
